// File: src/sbl_pkg.sv
// Shared constants, command and status types for the spectrum bar level block.
package sbl_pkg;

	localparam int BIN_COUNT    = 64;
	localparam int BIN_W        = $clog2(BIN_COUNT);
	localparam int CUR_W        = BIN_W + 1;
	localparam int MAX_PER_BIN  = 1024;
	localparam int LEN_W        = 11;
	localparam int CNT_W        = $clog2(MAX_PER_BIN + 1);
	localparam int SAMPLE_BITS  = 16;
	localparam int SQ_W         = 2 * SAMPLE_BITS;
	localparam int ROOT_STEPS   = SQ_W / 2;
	localparam int STEP_W       = $clog2(ROOT_STEPS);
	localparam int SUM_W        = 26;
	localparam int HEIGHT_SCALE = 480;
	localparam int HEIGHT_MAX   = 479;
	localparam int HGT_W        = 9;
	localparam int SCALE_W      = 9;
	localparam int HSHIFT       = 15;
	localparam int PROD_W       = SUM_W + SCALE_W;
	localparam int SCREEN_WIDTH = 640;
	localparam int BAR_STEP     = SCREEN_WIDTH / BIN_COUNT;
	localparam int X_W          = 10;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SQ_RE = 7'b0000010,
		ST_SQ_IM = 7'b0000100,
		ST_ROOT  = 7'b0001000,
		ST_ACC   = 7'b0010000,
		ST_HGT   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} sbl_state_t;

	typedef struct packed {
		logic load;
		logic sq_re;
		logic sq_im;
		logic root_step;
		logic acc;
		logic hgt;
		logic emit;
	} sbl_cmd_t;

	typedef struct packed {
		logic discard;
		logic bin_done;
		logic out_free;
	} sbl_sts_t;

endpackage

// File: src/sbl_if.sv
// Handshake channel interfaces for samples, bar results and configuration.
interface sbl_sample_if;
	import sbl_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_re;
	logic signed [SAMPLE_BITS-1:0] sample_im;
	logic                          end_of_block;

	modport source (output valid, sample_re, sample_im, end_of_block, input ready);
	modport sink   (input valid, sample_re, sample_im, end_of_block, output ready);
endinterface

interface sbl_bar_if;
	import sbl_pkg::*;
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] bin_number;
	logic [X_W-1:0]   bar_left_x;
	logic [HGT_W-1:0] bar_height;
	logic             final_bin;

	modport source (output valid, bin_number, bar_left_x, bar_height, final_bin, input ready);
	modport sink   (input valid, bin_number, bar_left_x, bar_height, final_bin, output ready);
endinterface

interface sbl_cfg_if;
	import sbl_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] samples_per_bin;

	modport source (output valid, samples_per_bin, input ready);
	modport sink   (input valid, samples_per_bin, output ready);
endinterface

// File: src/spectrum_bar_levels_top.sv
// Top level of the spectrum bar level block: controller plus datapath.
//
//  channel  | modport | payload
//  ---------+---------+------------------------------------------------------
//  samples  | sink    | sample_re, sample_im (Q1.15), end_of_block
//  bars     | source  | bin_number, bar_left_x, bar_height, final_bin
//  cfg      | sink    | samples_per_bin
//
// A sample runs from its transfer to the next ready through squaring of the real and then
// the imaginary part on a shared 16x16 multiplier, the one-bit-per-cycle square root and
// an accumulate step. A sample that completes a bin adds a height multiply and an output
// load, and waits longer while the output register is still held by a stall.
// Samples after the last bin of a block are only loaded, not squared. Reset clears the bin
// counters and the output valid flag and sets samples_per_bin to 1.
module spectrum_bar_levels_top (
	input  logic      clk,
	input  logic      arst_n,
	sbl_cfg_if.sink   cfg,
	sbl_sample_if.sink samples,
	sbl_bar_if.source bars
);
	import sbl_pkg::*;

	sbl_cmd_t cmd;
	sbl_sts_t sts;
	logic     in_ready;

	assign samples.ready = in_ready;

	sbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbl_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_re    (samples.sample_re),
		.sample_im    (samples.sample_im),
		.end_of_block (samples.end_of_block),
		.cfg          (cfg),
		.bars         (bars),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// File: src/sbl_ctrl.sv
// Controller state machine sequencing load, square, root, accumulate, height and emit steps.
module sbl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sbl_pkg::sbl_sts_t sts,
	output sbl_pkg::sbl_cmd_t cmd
);
	import sbl_pkg::*;

	sbl_state_t        state_q;
	sbl_state_t        state_d;
	logic [STEP_W-1:0] step_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					// A surplus sample only needs its end marker, handled at load.
					if (!sts.discard) state_d = ST_SQ_RE;
				end
			end
			ST_SQ_RE: begin
				cmd.sq_re = 1'b1;
				state_d   = ST_SQ_IM;
			end
			ST_SQ_IM: begin
				cmd.sq_im = 1'b1;
				state_d   = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (step_q == '0) state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.bin_done ? ST_HGT : ST_IDLE;
			end
			ST_HGT: begin
				cmd.hgt = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQ_IM) begin
				step_q <= STEP_W'(ROOT_STEPS - 1);
			end else if (state_q == ST_ROOT) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

endmodule

// File: src/sbl_datapath.sv
// Datapath: squares, bit-serial square root, bin accumulation, height scaling, output register.
module sbl_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [sbl_pkg::SAMPLE_BITS-1:0] sample_re,
	input  logic signed [sbl_pkg::SAMPLE_BITS-1:0] sample_im,
	input  logic                                  end_of_block,
	sbl_cfg_if.sink                               cfg,
	sbl_bar_if.source                             bars,
	input  sbl_pkg::sbl_cmd_t                     cmd,
	output sbl_pkg::sbl_sts_t                     sts
);
	import sbl_pkg::*;

	logic [SAMPLE_BITS-1:0] re_abs_q;
	logic [SAMPLE_BITS-1:0] im_abs_q;
	logic                   eob_q;
	logic [SQ_W-1:0]        sq_q;
	logic [SQ_W-1:0]        res_q;
	logic [SQ_W-1:0]        bit_q;
	logic [SUM_W-1:0]       hsum_q;
	logic [BIN_W-1:0]       obin_q;
	logic [PROD_W-1:0]      prod_q;

	logic [LEN_W-1:0]       spb_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       count_q;
	logic [CUR_W-1:0]       cur_bin_q;
	logic                   out_valid_q;
	logic [BIN_W-1:0]       out_bin_q;
	logic [X_W-1:0]         out_x_q;
	logic [HGT_W-1:0]       out_h_q;
	logic                   out_final_q;

	logic [SAMPLE_BITS-1:0] re_abs;
	logic [SAMPLE_BITS-1:0] im_abs;
	logic [SAMPLE_BITS-1:0] mul_a;
	logic [SQ_W-1:0]        square;
	logic [SQ_W-1:0]        trial;
	logic [SUM_W:0]         sum_ext;
	logic [SUM_W-1:0]       sum_sat;
	logic [CNT_W-1:0]       count_nxt;
	logic [CNT_W-1:0]       len_eff;
	logic [PROD_W-HSHIFT-1:0] h_full;
	logic [HGT_W-1:0]       h_sat;

	// Two's complement magnitude; the most negative value maps to 2^(SAMPLE_BITS-1).
	assign re_abs = sample_re[SAMPLE_BITS-1] ? (~sample_re + 1'b1) : sample_re;
	assign im_abs = sample_im[SAMPLE_BITS-1] ? (~sample_im + 1'b1) : sample_im;

	// One multiplier, used for the real square and then the imaginary square.
	assign mul_a  = cmd.sq_re ? re_abs_q : im_abs_q;
	assign square = SQ_W'(mul_a) * SQ_W'(mul_a);
	assign trial  = res_q + bit_q;

	always_comb begin
		if (spb_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (int'(spb_q) > MAX_PER_BIN) begin
			len_eff = CNT_W'(MAX_PER_BIN);
		end else begin
			len_eff = CNT_W'(spb_q);
		end
	end

	assign sum_ext   = {1'b0, sum_q} + (SUM_W+1)'(res_q[SAMPLE_BITS-1:0]);
	assign sum_sat   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
	assign count_nxt = count_q + 1'b1;

	assign h_full = prod_q[PROD_W-1:HSHIFT];
	assign h_sat  = (h_full > (PROD_W-HSHIFT)'(HEIGHT_MAX)) ? HGT_W'(HEIGHT_MAX)
	                                                      : h_full[HGT_W-1:0];

	assign sts.discard  = (cur_bin_q == CUR_W'(BIN_COUNT));
	assign sts.bin_done = (count_nxt >= len_eff);
	assign sts.out_free = !out_valid_q || bars.ready;

	assign cfg.ready       = 1'b1;
	assign bars.valid      = out_valid_q;
	assign bars.bin_number = out_bin_q;
	assign bars.bar_left_x = out_x_q;
	assign bars.bar_height = out_h_q;
	assign bars.final_bin  = out_final_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			re_abs_q <= re_abs;
			im_abs_q <= im_abs;
			eob_q    <= end_of_block;
		end
		if (cmd.sq_re) begin
			sq_q <= square;
		end else if (cmd.sq_im) begin
			sq_q  <= sq_q + square;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (cmd.root_step) begin
			if (sq_q >= trial) begin
				sq_q  <= sq_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.acc && sts.bin_done) begin
			hsum_q <= sum_sat;
			obin_q <= cur_bin_q[BIN_W-1:0];
		end
		if (cmd.hgt) begin
			prod_q <= PROD_W'(hsum_q) * PROD_W'(HEIGHT_SCALE);
		end
		if (cmd.emit) begin
			out_bin_q   <= obin_q;
			out_x_q     <= X_W'(obin_q * BAR_STEP);
			out_h_q     <= h_sat;
			out_final_q <= (obin_q == BIN_W'(BIN_COUNT - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q       <= LEN_W'(1);
			sum_q       <= '0;
			count_q     <= '0;
			cur_bin_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				spb_q <= cfg.samples_per_bin;
			end
			if (cmd.load && sts.discard && end_of_block) begin
				cur_bin_q <= '0;
				sum_q     <= '0;
				count_q   <= '0;
			end else if (cmd.acc) begin
				// The marked sample still counts if it completes its bin; the block end then clears the bin state.
				if (eob_q) begin
					cur_bin_q <= '0;
					sum_q     <= '0;
					count_q   <= '0;
				end else if (sts.bin_done) begin
					cur_bin_q <= cur_bin_q + 1'b1;
					sum_q     <= '0;
					count_q   <= '0;
				end else begin
					sum_q   <= sum_sat;
					count_q <= count_nxt;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (bars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || bars.ready))
		else $error("result loaded while the output register was still held");

	a_acc_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> (cur_bin_q < CUR_W'(BIN_COUNT)))
		else $error("accumulation after the last bin of the block");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_bin_q <= CUR_W'(BIN_COUNT))
		else $error("bin index ran past the bin count");

	a_root_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> (bit_q == '0))
		else $error("square root not finished at accumulation");
`endif

endmodule
